// File: src/gbc_pkg.sv
package gbc_pkg;

    // Fixed widths of the configuration registers and of the result count.
    localparam int CFG_W     = 9;
    localparam int COUNT_W   = 16;
    localparam int MAX_DIM_DEFAULT = 256;
    localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;

    // Configuration register indexes.
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHECK,
        ST_CHECK_DRAIN,
        ST_DECIDE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_POP_RD,
        ST_POP_EV,
        ST_NB_RD,
        ST_NB_EV,
        ST_FINISH
    } state_t;

endpackage

// File: src/gbc_ram.sv
module gbc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/grid_blob_counter_with_shape_check_core.sv
// Counts the 4-connected regions of occupied cells in a binary grid. The grid arrives one
// cell per request in raster order, the last cell marked by s_tlast, and is stored at one
// cell per cycle. After the last cell the block sweeps the grid once, one cell per cycle
// over (row_count+1)*(col_count+1) positions, looking for a 2x2 window with exactly three
// occupied cells (outside the grid counts as empty); the same sweep clears the visited map.
// If such a window exists the result is bad_placement=1 with a count of zero. Otherwise a
// breadth-first flood fill runs through the visited map and a coordinate queue: each grid
// cell is read in the outer scan, and each cell that joins a region adds a queue pop plus
// up to four neighbor reads of the cell and visited memories, which have one read port
// each. One result is produced per grid. The next grid's cells are accepted only while the
// block is loading, but a finished result may wait in the output register while loading
// goes on. row_count and col_count are sampled at the last cell; 0 acts as 1 and values
// above MAX_DIM act as MAX_DIM.
module grid_blob_counter_with_shape_check_core #(
    parameter int MAX_DIM = gbc_pkg::MAX_DIM_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Input cells. s_tdata: bit 0 occupied, bits 7:1 zero.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,
    input  logic                      s_tlast,
    // Results. m_tdata: bits 15:0 region_count. m_tuser: bit 0 bad_placement.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [15:0]               m_tdata,
    output logic [0:0]                m_tuser,
    // Configuration writes: index 0 row_count, index 1 col_count.
    input  logic                      cfg_we,
    input  logic                      cfg_addr,
    input  logic [gbc_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(MAX_DIM);
    localparam int EW    = $clog2(MAX_DIM + 1);
    localparam int CW    = (EW > gbc_pkg::CFG_W) ? EW : gbc_pkg::CFG_W;
    localparam int QW    = AW + 2 * RW;
    localparam int NW    = gbc_pkg::COUNT_W;

    function automatic logic [EW-1:0] clamp_dim(input logic [gbc_pkg::CFG_W-1:0] v);
        logic [CW-1:0] x;
        begin
            x = CW'(v);
            if (x == '0) return EW'(1);
            if (x > CW'(MAX_DIM)) return EW'(MAX_DIM);
            return EW'(x);
        end
    endfunction

    // Registers.
    gbc_pkg::state_t state_reg, state_next;
    logic [gbc_pkg::CFG_W-1:0] row_cfg_reg, col_cfg_reg;
    logic [EW-1:0] rows_reg, rows_next, cols_reg, cols_next;
    logic [AW:0]   total_reg, total_next;
    logic [AW:0]   load_pos_reg, load_pos_next;
    logic [EW-1:0] r_reg, r_next, c_reg, c_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          p1_valid_reg, p1_valid_next;
    logic          p1_in_reg, p1_in_next;
    logic [EW-1:0] p1_r_reg, p1_r_next, p1_c_reg, p1_c_next;
    logic          left_reg, left_next, upleft_reg, upleft_next;
    logic          bad_reg, bad_next;
    logic [EW-1:0] cur_r_reg, cur_r_next, cur_c_reg, cur_c_next;
    logic [AW-1:0] cur_idx_reg, cur_idx_next;
    logic [EW-1:0] nb_r_reg, nb_r_next, nb_c_reg, nb_c_next;
    logic [AW-1:0] nb_idx_reg, nb_idx_next;
    logic [1:0]    k_reg, k_next;
    logic [AW:0]   head_reg, head_next, tail_reg, tail_next;
    logic [NW-1:0] count_reg, count_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_bad_reg, m_bad_next;
    logic [NW-1:0] m_count_reg, m_count_next;

    // Memory ports.
    logic          cell_we, cell_wdata, cell_rdata;
    logic [AW-1:0] cell_waddr, cell_raddr;
    logic          seen_we, seen_wdata, seen_rdata;
    logic [AW-1:0] seen_waddr, seen_raddr;
    logic          queue_we;
    logic [QW-1:0] queue_wdata, queue_rdata;
    logic [AW-1:0] queue_waddr, queue_raddr;
    logic          lb_we, lb_wdata, lb_rdata;
    logic [EW-1:0] lb_waddr, lb_raddr;

    gbc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_cell_ram (
        .clk(aclk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
        .raddr(cell_raddr), .rdata(cell_rdata)
    );

    gbc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_seen_ram (
        .clk(aclk), .we(seen_we), .waddr(seen_waddr), .wdata(seen_wdata),
        .raddr(seen_raddr), .rdata(seen_rdata)
    );

    gbc_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue_ram (
        .clk(aclk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
        .raddr(queue_raddr), .rdata(queue_rdata)
    );

    // Line buffer holding the previous row of the extended grid during the window check.
    gbc_ram #(.WIDTH(1), .DEPTH(MAX_DIM + 1)) u_line_ram (
        .clk(aclk), .we(lb_we), .waddr(lb_waddr), .wdata(lb_wdata),
        .raddr(lb_raddr), .rdata(lb_rdata)
    );

    // Grid size under the current register values, so a write takes effect at once.
    logic [EW-1:0] rows_c, cols_c;
    logic [AW:0]   total_cfg_c;
    assign rows_c      = clamp_dim(row_cfg_reg);
    assign cols_c      = clamp_dim(col_cfg_reg);
    assign total_cfg_c = (AW+1)'(rows_c) * (AW+1)'(cols_c);

    assign s_tready = (state_reg == gbc_pkg::ST_LOAD);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_count_reg;
    assign m_tuser  = m_bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= gbc_pkg::ST_LOAD;
            row_cfg_reg  <= gbc_pkg::DIM_RESET;
            col_cfg_reg  <= gbc_pkg::DIM_RESET;
            load_pos_reg <= '0;
            p1_valid_reg <= 1'b0;
            bad_reg      <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            load_pos_reg <= load_pos_next;
            p1_valid_reg <= p1_valid_next;
            bad_reg      <= bad_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    gbc_pkg::REG_ROW_COUNT: row_cfg_reg <= cfg_wdata;
                    gbc_pkg::REG_COL_COUNT: col_cfg_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        rows_reg      <= rows_next;
        cols_reg      <= cols_next;
        total_reg     <= total_next;
        r_reg         <= r_next;
        c_reg         <= c_next;
        idx_reg       <= idx_next;
        p1_in_reg     <= p1_in_next;
        p1_r_reg      <= p1_r_next;
        p1_c_reg      <= p1_c_next;
        left_reg      <= left_next;
        upleft_reg    <= upleft_next;
        cur_r_reg     <= cur_r_next;
        cur_c_reg     <= cur_c_next;
        cur_idx_reg   <= cur_idx_next;
        nb_r_reg      <= nb_r_next;
        nb_c_reg      <= nb_c_next;
        nb_idx_reg    <= nb_idx_next;
        k_reg         <= k_next;
        m_bad_reg     <= m_bad_next;
        m_count_reg   <= m_count_next;
    end

    logic       s_acc;
    logic       in_grid;
    logic       cur_cell, up_cell;
    logic [2:0] win_sum;
    logic       do_adv;
    logic       nb_ok;

    always_comb begin
        state_next    = state_reg;
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        total_next    = total_reg;
        load_pos_next = load_pos_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        idx_next      = idx_reg;
        p1_valid_next = 1'b0;
        p1_in_next    = p1_in_reg;
        p1_r_next     = p1_r_reg;
        p1_c_next     = p1_c_reg;
        left_next     = left_reg;
        upleft_next   = upleft_reg;
        bad_next      = bad_reg;
        cur_r_next    = cur_r_reg;
        cur_c_next    = cur_c_reg;
        cur_idx_next  = cur_idx_reg;
        nb_r_next     = nb_r_reg;
        nb_c_next     = nb_c_reg;
        nb_idx_next   = nb_idx_reg;
        k_next        = k_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_bad_next    = m_bad_reg;
        m_count_next  = m_count_reg;

        cell_we     = 1'b0;
        cell_waddr  = load_pos_reg[AW-1:0];
        cell_wdata  = s_tdata[0];
        cell_raddr  = idx_reg;
        seen_we     = 1'b0;
        seen_waddr  = idx_reg;
        seen_wdata  = 1'b0;
        seen_raddr  = idx_reg;
        queue_we    = 1'b0;
        queue_waddr = tail_reg[AW-1:0];
        queue_wdata = {idx_reg, c_reg[RW-1:0], r_reg[RW-1:0]};
        queue_raddr = head_reg[AW-1:0];
        lb_raddr    = c_reg;
        lb_waddr    = p1_c_reg;
        lb_we       = 1'b0;

        s_acc   = s_tvalid && (state_reg == gbc_pkg::ST_LOAD);
        in_grid = (r_reg < rows_reg) && (c_reg < cols_reg);
        do_adv  = 1'b0;
        nb_ok   = 1'b0;

        // Second stage of the window check: combine the cell just read with the row above.
        cur_cell = p1_in_reg && cell_rdata;
        up_cell  = (p1_r_reg != '0) && lb_rdata;
        lb_wdata = cur_cell;
        win_sum  = 3'(cur_cell) + 3'(up_cell) + 3'(left_reg) + 3'(upleft_reg);
        if (p1_valid_reg) begin
            lb_we       = 1'b1;
            left_next   = cur_cell;
            upleft_next = up_cell;
            if ((p1_r_reg != '0) && (p1_c_reg != '0) && (win_sum == 3'd3)) begin
                bad_next = 1'b1;
            end
        end

        unique case (state_reg)
            gbc_pkg::ST_LOAD: begin
                if (s_acc) begin
                    cell_we = (load_pos_reg < total_cfg_c);
                    if (load_pos_reg < (AW+1)'(CELLS)) begin
                        load_pos_next = load_pos_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        load_pos_next = '0;
                        rows_next     = rows_c;
                        cols_next     = cols_c;
                        total_next    = total_cfg_c;
                        r_next        = '0;
                        c_next        = '0;
                        idx_next      = '0;
                        bad_next      = 1'b0;
                        count_next    = '0;
                        state_next    = gbc_pkg::ST_CHECK;
                    end
                end
            end
            gbc_pkg::ST_CHECK: begin
                // First stage: read the cell and the line buffer, clear the visited entry.
                p1_valid_next = 1'b1;
                p1_in_next    = in_grid;
                p1_r_next     = r_reg;
                p1_c_next     = c_reg;
                seen_we       = in_grid;
                if (in_grid) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (c_reg == cols_reg) begin
                    c_next = '0;
                    r_next = r_reg + 1'b1;
                    if (r_reg == rows_reg) begin
                        state_next = gbc_pkg::ST_CHECK_DRAIN;
                    end
                end else begin
                    c_next = c_reg + 1'b1;
                end
            end
            gbc_pkg::ST_CHECK_DRAIN: begin
                state_next = gbc_pkg::ST_DECIDE;
            end
            gbc_pkg::ST_DECIDE: begin
                r_next   = '0;
                c_next   = '0;
                idx_next = '0;
                state_next = bad_reg ? gbc_pkg::ST_FINISH : gbc_pkg::ST_SCAN_RD;
            end
            gbc_pkg::ST_SCAN_RD: begin
                state_next = gbc_pkg::ST_SCAN_EV;
            end
            gbc_pkg::ST_SCAN_EV: begin
                if (cell_rdata && !seen_rdata) begin
                    if (count_reg != '1) begin
                        count_next = count_reg + 1'b1;
                    end
                    seen_we     = 1'b1;
                    seen_wdata  = 1'b1;
                    queue_we    = 1'b1;
                    queue_waddr = '0;
                    head_next   = '0;
                    tail_next   = (AW+1)'(1);
                    state_next  = gbc_pkg::ST_POP_RD;
                end else begin
                    do_adv = 1'b1;
                end
            end
            gbc_pkg::ST_POP_RD: begin
                if (head_reg == tail_reg) begin
                    do_adv = 1'b1;
                end else begin
                    head_next  = head_reg + 1'b1;
                    state_next = gbc_pkg::ST_POP_EV;
                end
            end
            gbc_pkg::ST_POP_EV: begin
                cur_idx_next = queue_rdata[QW-1 -: AW];
                cur_c_next   = EW'(queue_rdata[2*RW-1 -: RW]);
                cur_r_next   = EW'(queue_rdata[RW-1:0]);
                k_next       = 2'd0;
                state_next   = gbc_pkg::ST_NB_RD;
            end
            gbc_pkg::ST_NB_RD: begin
                // Neighbor order: up, left, right, down.
                case (k_reg)
                    2'd0: begin
                        nb_ok       = (cur_r_reg != '0);
                        nb_r_next   = cur_r_reg - 1'b1;
                        nb_c_next   = cur_c_reg;
                        nb_idx_next = cur_idx_reg - AW'(cols_reg);
                    end
                    2'd1: begin
                        nb_ok       = (cur_c_reg != '0);
                        nb_r_next   = cur_r_reg;
                        nb_c_next   = cur_c_reg - 1'b1;
                        nb_idx_next = cur_idx_reg - 1'b1;
                    end
                    2'd2: begin
                        nb_ok       = ((cur_c_reg + 1'b1) < cols_reg);
                        nb_r_next   = cur_r_reg;
                        nb_c_next   = cur_c_reg + 1'b1;
                        nb_idx_next = cur_idx_reg + 1'b1;
                    end
                    default: begin
                        nb_ok       = ((cur_r_reg + 1'b1) < rows_reg);
                        nb_r_next   = cur_r_reg + 1'b1;
                        nb_c_next   = cur_c_reg;
                        nb_idx_next = cur_idx_reg + AW'(cols_reg);
                    end
                endcase
                cell_raddr = nb_idx_next;
                seen_raddr = nb_idx_next;
                if (nb_ok) begin
                    state_next = gbc_pkg::ST_NB_EV;
                end else if (k_reg == 2'd3) begin
                    state_next = gbc_pkg::ST_POP_RD;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            gbc_pkg::ST_NB_EV: begin
                if (cell_rdata && !seen_rdata) begin
                    seen_we     = 1'b1;
                    seen_waddr  = nb_idx_reg;
                    seen_wdata  = 1'b1;
                    queue_we    = 1'b1;
                    queue_wdata = {nb_idx_reg, nb_c_reg[RW-1:0], nb_r_reg[RW-1:0]};
                    tail_next   = tail_reg + 1'b1;
                end
                if (k_reg == 2'd3) begin
                    state_next = gbc_pkg::ST_POP_RD;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = gbc_pkg::ST_NB_RD;
                end
            end
            gbc_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_bad_next   = bad_reg;
                    m_count_next = bad_reg ? '0 : count_reg;
                    state_next   = gbc_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = gbc_pkg::ST_LOAD;
            end
        endcase

        // Step the outer raster scan to the next start candidate.
        if (do_adv) begin
            if ((AW+1)'(idx_reg) + 1'b1 == total_reg) begin
                state_next = gbc_pkg::ST_FINISH;
            end else begin
                idx_next = idx_reg + 1'b1;
                if (c_reg + 1'b1 == cols_reg) begin
                    c_next = '0;
                    r_next = r_reg + 1'b1;
                end else begin
                    c_next = c_reg + 1'b1;
                end
                state_next = gbc_pkg::ST_SCAN_RD;
            end
        end
    end

    // The queue never drains past what was pushed.
    a_queue_order: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    // Each grid cell is queued at most once per grid, so the queue stays within the grid.
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gbc_pkg::ST_POP_RD || state_reg == gbc_pkg::ST_NB_RD ||
         state_reg == gbc_pkg::ST_NB_EV) |-> tail_reg <= total_reg)
        else $error("queue grew beyond the grid");

    // A bad placement result always carries a zero count.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gbc_pkg::ST_FINISH && state_next == gbc_pkg::ST_LOAD && bad_reg)
        |=> (m_tvalid && m_tuser[0] && m_tdata == '0))
        else $error("bad placement result with nonzero count");

endmodule
